// File: src/lifo_list_with_search_remove_defines.svh
// ----------------------------------------------------------------------------
// LIFO list assertion macros
// Shared assertion wrappers for the LIFO list with search and remove; empty
// when the code is read for synthesis.
// ----------------------------------------------------------------------------
`ifndef LIFO_LIST_WITH_SEARCH_REMOVE_DEFINES_SVH
`define LIFO_LIST_WITH_SEARCH_REMOVE_DEFINES_SVH

`ifndef SYNTHESIS

// Check that a property holds at every rising clock edge outside reset
`define LSR_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("lsr: property check failed");

// Check that a condition never occurs outside reset
`define LSR_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("lsr: forbidden condition seen");

`else

`define LSR_ASSERT(lbl, clk, rst, prop)
`define LSR_NEVER(lbl, clk, rst, expr)

`endif

`endif

// File: src/lsr_pkg.sv
// ----------------------------------------------------------------------------
// LIFO list package
// Command and status codes, field widths and the cell control word.
// ----------------------------------------------------------------------------
`default_nettype none

package lsr_pkg;

   localparam int CMD_W    = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
   localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
   localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
   localparam logic [CMD_W-1:0] CMD_FRONT  = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // cell move codes
   localparam logic [1:0] MODE_HOLD = 2'd0;
   localparam logic [1:0] MODE_DOWN = 2'd1;
   localparam logic [1:0] MODE_UP   = 2'd2;

   typedef struct packed {
      logic [1:0] mode;
      logic       wr_en;
   } lsr_ctl_type;

endpackage

`default_nettype wire

// File: src/lsr_if.sv
// ----------------------------------------------------------------------------
// LIFO list channel interfaces
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
`default_nettype none

interface lsr_req_if import lsr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [CMD_W-1:0]          cmd;
   logic signed [VALUE_W-1:0] operand_value;

   modport source (output valid, output cmd, output operand_value, input ready);
   modport sink   (input valid, input cmd, input operand_value, output ready);
endinterface

interface lsr_rsp_if import lsr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [STATUS_W-1:0]       status;
   logic                      found;
   logic signed [VALUE_W-1:0] front_value;
   logic [COUNT_W-1:0]        count;

   modport source (output valid, output status, output found, output front_value,
                   output count, input ready);
   modport sink   (input valid, input status, input found, input front_value,
                   input count, output ready);
endinterface

`default_nettype wire

// File: src/lsr_cell.sv
// ----------------------------------------------------------------------------
// LIFO list cell
// One stored value; takes its upper or lower neighbor, the tail write or holds.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_cell import lsr_pkg::*; (
   input  wire logic                      clock,
   input  wire lsr_ctl_type               ctl,
   input  wire logic                      wr_sel,
   input  wire logic signed [VALUE_W-1:0] down_in,
   input  wire logic signed [VALUE_W-1:0] up_in,
   input  wire logic signed [VALUE_W-1:0] tail_in,
   output      logic signed [VALUE_W-1:0] value
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;

   // pick the next value from the move code
   always_comb begin
      unique case (ctl.mode)
         MODE_HOLD: value_in = value_ff;
         MODE_DOWN: value_in = down_in;
         MODE_UP:   value_in = wr_sel ? tail_in : up_in;
         default:   value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

`default_nettype wire

// File: src/lsr_chain.sv
// ----------------------------------------------------------------------------
// LIFO list cell chain
// Row of cells, front at cell 0; decodes the tail write index for each cell.
// ----------------------------------------------------------------------------
`default_nettype none

module lsr_chain import lsr_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic                       clock,
   input  wire lsr_ctl_type                ctl,
   input  wire logic [$clog2(DEPTH)-1:0]   wr_idx,
   input  wire logic signed [VALUE_W-1:0]  push_data,
   output      logic signed [VALUE_W-1:0]  head_value
);

   localparam int IW = $clog2(DEPTH);

   logic signed [VALUE_W-1:0] vals [DEPTH];

   // build the row, each cell wired to its two neighbors
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_W-1:0] down_w;
      logic signed [VALUE_W-1:0] up_w;
      logic                      sel_w;

      if (i == 0) begin : g_first
         assign down_w = push_data;
      end else begin : g_mid
         assign down_w = vals[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign up_w = '0;
      end else begin : g_inner
         assign up_w = vals[i+1];
      end

      assign sel_w = ctl.wr_en && (wr_idx == IW'(i));

      lsr_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .wr_sel  (sel_w),
         .down_in (down_w),
         .up_in   (up_w),
         .tail_in (vals[0]),
         .value   (vals[i])
      );
   end

   assign head_value = vals[0];

endmodule

`default_nettype wire

// File: src/lifo_list_with_search_remove.sv
// ----------------------------------------------------------------------------
// LIFO list with search and remove
// Bounded list of signed 32-bit values held in a row of cells, newest first.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command word (cmd, operand_value); rsp_chan returns
//   one result word per command (status, found, front_value, count). Both use
//   valid/ready; a word moves on a clock edge with valid and ready high.
//   Push, pop, clear, read front and unused codes load the result word at once:
//   it is valid the cycle after the command is taken.
//   Find and remove rotate the whole list through the front cell, one entry a
//   cycle, dropping matches on remove; the result word is loaded as the last
//   entry passes cell 0, or at once when the list is empty.
//   One command is in work at a time; a new command is taken once the block
//   is idle and the result register is empty or being read in that cycle, so
//   simple commands sustain one word per cycle while the receiver keeps up.
//   A stalled receiver holds the result word and blocks further commands.
//   Synchronous reset empties the list and drops any pending result; stored
//   values themselves are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none
`include "lifo_list_with_search_remove_defines.svh"

module lifo_list_with_search_remove import lsr_pkg::*; #(
   parameter int DEPTH = 64
) (
   input  wire logic  clock,
   input  wire logic  reset,
   lsr_req_if.sink    req_chan,
   lsr_rsp_if.source  rsp_chan
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = $clog2(DEPTH);
   localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
   localparam logic [CW-1:0] ONE_C   = CW'(1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic                      state_ff, state_in;
   logic [CMD_W-1:0]          cmd_ff, cmd_in;
   logic signed [VALUE_W-1:0] opnd_ff, opnd_in;
   logic [CW-1:0]             cnt_ff, cnt_in;
   logic [CW-1:0]             r_ff, r_in;
   logic [CW-1:0]             k_ff, k_in;
   logic                      found_ff, found_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic                      rsp_found_ff, rsp_found_in;
   logic signed [VALUE_W-1:0] rsp_front_ff, rsp_front_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;

   logic                      accept;
   logic                      rsp_load;
   logic                      keep;
   logic                      head_match;
   logic [CW-1:0]             tail_pos;
   logic [CW+COUNT_W-1:0]     cnt_ext;
   logic signed [VALUE_W-1:0] head_value;
   lsr_ctl_type               ctl;

   // take a command only when idle and the result register frees up
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   assign head_match = (head_value == opnd_ff);
   assign keep       = (cmd_ff == CMD_FIND) || !head_match;
   assign tail_pos   = r_ff + k_ff - ONE_C;

   // command decode and rotation control
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      opnd_in       = opnd_ff;
      cnt_in        = cnt_ff;
      r_in          = r_ff;
      k_in          = k_ff;
      found_in      = found_ff;
      rsp_load      = 1'b0;
      rsp_status_in = STATUS_OK;
      rsp_found_in  = 1'b0;
      rsp_front_in  = '0;
      ctl.mode      = MODE_HOLD;
      ctl.wr_en     = 1'b0;

      if (state_ff == S_RUN) begin
         // move the front entry to the tail, or drop it on a match
         ctl.mode  = MODE_UP;
         ctl.wr_en = keep;
         r_in      = r_ff - ONE_C;
         k_in      = k_ff + CW'(keep);
         found_in  = found_ff | head_match;
         if (r_ff == ONE_C) begin
            state_in = S_IDLE;
            rsp_load = 1'b1;
            if (cmd_ff == CMD_FIND) begin
               rsp_found_in = found_ff | head_match;
            end else begin
               cnt_in = k_ff + CW'(keep);
            end
         end
      end else if (accept) begin
         rsp_load = 1'b1;
         unique case (req_chan.cmd)
            CMD_PUSH: begin
               if (cnt_ff == DEPTH_C) begin
                  rsp_status_in = STATUS_FULL;
               end else begin
                  ctl.mode = MODE_DOWN;
                  cnt_in   = cnt_ff + ONE_C;
               end
            end
            CMD_POP: begin
               if (cnt_ff == '0) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  ctl.mode = MODE_UP;
                  cnt_in   = cnt_ff - ONE_C;
               end
            end
            CMD_CLEAR: begin
               cnt_in = '0;
            end
            CMD_FRONT: begin
               if (cnt_ff == '0) begin
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_front_in = head_value;
               end
            end
            CMD_REMOVE, CMD_FIND: begin
               // start a full rotation unless the list is empty
               if (cnt_ff != '0) begin
                  rsp_load = 1'b0;
                  state_in = S_RUN;
                  cmd_in   = req_chan.cmd;
                  opnd_in  = req_chan.operand_value;
                  r_in     = cnt_ff;
                  k_in     = '0;
                  found_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign cnt_ext      = {{COUNT_W{1'b0}}, cnt_in};
   assign rsp_count_in = cnt_ext[COUNT_W-1:0];

   // hold the result word until taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         r_ff         <= '0;
         k_ff         <= '0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         r_ff         <= r_in;
         k_ff         <= k_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      opnd_ff <= opnd_in;
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_found_ff  <= rsp_found_in;
         rsp_front_ff  <= rsp_front_in;
         rsp_count_ff  <= rsp_count_in;
      end
   end

   lsr_chain #(
      .DEPTH (DEPTH)
   ) u_chain (
      .clock      (clock),
      .ctl        (ctl),
      .wr_idx     (tail_pos[IW-1:0]),
      .push_data  (req_chan.operand_value),
      .head_value (head_value)
   );

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found       = rsp_found_ff;
   assign rsp_chan.front_value = rsp_front_ff;
   assign rsp_chan.count       = rsp_count_ff;

   // checks
   `LSR_NEVER(a_cnt_bound, clock, reset, cnt_ff > DEPTH_C)
   `LSR_NEVER(a_no_take_in_run, clock, reset, (state_ff == S_RUN) && req_chan.ready)
   `LSR_NEVER(a_run_has_work, clock, reset, (state_ff == S_RUN) && (r_ff == '0))
   `LSR_ASSERT(a_run_ends, clock, reset, ((state_ff == S_RUN) && (r_ff == ONE_C)) |=> ((state_ff == S_IDLE) && rsp_valid_ff))
   `LSR_ASSERT(a_push_grows, clock, reset, (accept && (req_chan.cmd == CMD_PUSH) && (cnt_ff != DEPTH_C)) |=> (cnt_ff == $past(cnt_ff) + ONE_C))

endmodule

`default_nettype wire

// File: test/lifo_list_with_search_remove_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LIFO list with search and remove: testbench
// Drives command words into the list and checks each result word against a
// behavioral copy of the list kept in the testbench. Directed tests cover the
// empty, full and extreme-value cases. Random tests mix growing, churning and
// draining phases, and both channel sides idle in random bursts.
// ----------------------------------------------------------------------------
module lifo_list_with_search_remove_tb;
   import lsr_pkg::*;

   localparam int DEPTH        = 64;
   localparam int LONG_STALL   = 300;
   localparam int DRAIN_CYCLES = DEPTH + 40;

   // unused command codes, expected to act as no-ops
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;

   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7fff_ffff;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      found;
      logic signed [VALUE_W-1:0] front_value;
      logic [COUNT_W-1:0]        count;
   } list_result_type;

   logic clock;
   logic reset;

   lsr_req_if req_bus ();
   lsr_rsp_if rsp_bus ();

   lifo_list_with_search_remove #(
      .DEPTH(DEPTH)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus)
   );

   // expected list contents, oldest at index 0
   logic signed [VALUE_W-1:0] list_vals [DEPTH];
   int                        list_held = 0;

   list_result_type           pending_results [$];
   logic signed [VALUE_W-1:0] value_pool [8];
   int                        error_count    = 0;
   bit                        idle_on        = 1'b1;
   bit                        long_stall_req = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Work out the result word of one command and advance the expected list
   function automatic list_result_type lifo_next_result(
      input logic [CMD_W-1:0]          op,
      input logic signed [VALUE_W-1:0] val
   );
      list_result_type res;
      int              kept;
      res.status      = STATUS_OK;
      res.found       = 1'b0;
      res.front_value = '0;
      case (op)
         CMD_PUSH: begin
            if (list_held >= DEPTH) begin
               res.status = STATUS_FULL;
            end else begin
               list_vals[list_held] = val;
               list_held++;
            end
         end
         CMD_POP: begin
            if (list_held == 0) res.status = STATUS_EMPTY;
            else list_held--;
         end
         CMD_REMOVE: begin
            // compact survivors toward the oldest end, order kept
            kept = 0;
            for (int i = 0; i < list_held; i++) begin
               if (list_vals[i] != val) begin
                  list_vals[kept] = list_vals[i];
                  kept++;
               end
            end
            list_held = kept;
         end
         CMD_CLEAR: list_held = 0;
         CMD_FIND: begin
            for (int i = 0; i < list_held; i++) begin
               if (list_vals[i] == val) res.found = 1'b1;
            end
         end
         CMD_FRONT: begin
            if (list_held == 0) res.status = STATUS_EMPTY;
            else res.front_value = list_vals[list_held-1];
         end
         default: ;
      endcase
      res.count = COUNT_W'(list_held);
      return res;
   endfunction

   // Offer one command word, hold it until taken, then log its expected result
   task automatic send_word(input logic [CMD_W-1:0] op, input logic signed [VALUE_W-1:0] val);
      if (idle_on && $urandom_range(0, 5) == 0) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_bus.valid         <= 1'b1;
      req_bus.cmd           <= op;
      req_bus.operand_value <= val;
      do @(posedge clock); while (!req_bus.ready);
      pending_results.push_back(lifo_next_result(op, val));
   endtask

   // Draw a fresh set of likely values so find and remove often hit
   task automatic refresh_pool();
      foreach (value_pool[k]) begin
         case ($urandom_range(0, 5))
            0:       value_pool[k] = VALUE_MIN;
            1:       value_pool[k] = VALUE_MAX;
            2:       value_pool[k] = '0;
            3:       value_pool[k] = -1;
            default: value_pool[k] = $urandom;
         endcase
      end
   endtask

   function automatic logic signed [VALUE_W-1:0] pick_value();
      if ($urandom_range(0, 3) == 0) return $urandom;
      return value_pool[$urandom_range(0, 7)];
   endfunction

   function automatic logic [CMD_W-1:0] pick_cmd(input int push_pct);
      int r;
      if ($urandom_range(0, 99) < push_pct) return CMD_PUSH;
      r = $urandom_range(0, 99);
      if (r < 30) return CMD_POP;
      if (r < 50) return CMD_REMOVE;
      if (r < 75) return CMD_FIND;
      if (r < 93) return CMD_FRONT;
      if (r < 97) return CMD_CLEAR;
      if (r < 99) return CMD_SPARE_LO;
      return CMD_SPARE_HI;
   endfunction

   // Every command but push on an empty list, plus the unused codes
   task automatic test_empty_list();
      send_word(CMD_POP, 32'sd0);
      send_word(CMD_FRONT, 32'sd0);
      send_word(CMD_FIND, 32'sd0);
      send_word(CMD_REMOVE, -1);
      send_word(CMD_CLEAR, 32'sd0);
      send_word(CMD_SPARE_LO, VALUE_MAX);
      send_word(CMD_SPARE_HI, VALUE_MIN);
   endtask

   // Extreme operand values through push, find, remove and read front
   task automatic test_value_extremes();
      send_word(CMD_PUSH, VALUE_MIN);
      send_word(CMD_PUSH, VALUE_MAX);
      send_word(CMD_PUSH, 32'sd0);
      send_word(CMD_PUSH, -1);
      send_word(CMD_FRONT, 32'sd0);
      send_word(CMD_FIND, VALUE_MAX);
      send_word(CMD_FIND, 32'sd1);
      send_word(CMD_REMOVE, VALUE_MIN);
      send_word(CMD_POP, 32'sd0);
      send_word(CMD_FRONT, 32'sd0);
      send_word(CMD_SPARE_LO, VALUE_MAX);
   endtask

   // Remove that empties the list, and clear on a non-empty list
   task automatic test_remove_to_empty();
      send_word(CMD_CLEAR, 32'sd0);
      send_word(CMD_PUSH, 32'sd5);
      send_word(CMD_PUSH, 32'sd5);
      send_word(CMD_REMOVE, 32'sd5);
      send_word(CMD_FIND, 32'sd5);
      send_word(CMD_PUSH, 32'sd9);
      send_word(CMD_CLEAR, 32'sd0);
   endtask

   // Fill to capacity, overflow, then search and compact a full list
   task automatic test_fill_and_overflow();
      refresh_pool();
      send_word(CMD_CLEAR, 32'sd0);
      repeat (DEPTH) send_word(CMD_PUSH, pick_value());
      send_word(CMD_PUSH, VALUE_MAX);
      send_word(CMD_PUSH, VALUE_MIN);
      send_word(CMD_FRONT, 32'sd0);
      send_word(CMD_FIND, value_pool[0]);
      send_word(CMD_REMOVE, value_pool[1]);
      send_word(CMD_POP, 32'sd0);
      send_word(CMD_FRONT, 32'sd0);
   endtask

   // Hold off the result side for a long stretch while commands keep coming
   task automatic test_result_backpressure();
      refresh_pool();
      long_stall_req = 1'b1;
      repeat (12) send_word(pick_cmd(60), pick_value());
   endtask

   // Random phases biased to grow, churn or drain the list
   task automatic test_random_mix(input int n_items);
      int push_pct;
      push_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (i % 40 == 0) begin
            refresh_pool();
            case ($urandom_range(0, 2))
               0:       push_pct = 80;
               1:       push_pct = 50;
               default: push_pct = 15;
            endcase
         end
         send_word(pick_cmd(push_pct), pick_value());
      end
   endtask

   // Result side: random stall bursts, and one long hold-off on request
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (long_stall_req) begin
            rsp_bus.ready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
            long_stall_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 9) == 0) begin
            rsp_bus.ready <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clock);
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // Compare each taken result word with the oldest expected one
   always @(posedge clock) begin : check_results
      list_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_results.size() == 0) begin
            $error("result word with no command outstanding");
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_count++;
            end
            if (rsp_bus.found !== want.found) begin
               $error("found: expected %0d, got %0d", want.found, rsp_bus.found);
               error_count++;
            end
            if (rsp_bus.front_value !== want.front_value) begin
               $error("front_value: expected %0d, got %0d", want.front_value,
                      rsp_bus.front_value);
               error_count++;
            end
            if (rsp_bus.count !== want.count) begin
               $error("count: expected %0d, got %0d", want.count, rsp_bus.count);
               error_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      reset                 <= 1'b1;
      req_bus.valid         <= 1'b0;
      req_bus.cmd           <= CMD_PUSH;
      req_bus.operand_value <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_value_extremes();
      test_remove_to_empty();
      test_fill_and_overflow();
      test_result_backpressure();
      test_random_mix(850);
      // last stretch at full rate on both sides
      idle_on = 1'b0;
      test_random_mix(100);
      req_bus.valid <= 1'b0;

      // drain outstanding results, then let any stray word show up
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
